FILE: src/rk4c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rk4c_pkg;

  localparam int PARTICLES = 1024;
  localparam int FRAC_BITS = 16;
  localparam int PART_W    = 10;
  localparam int IDX_W     = $clog2(PARTICLES);

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_STAGE1 = 3'd1;
  localparam logic [2:0] CMD_STAGE2 = 3'd2;
  localparam logic [2:0] CMD_STAGE3 = 3'd3;
  localparam logic [2:0] CMD_STAGE4 = 3'd4;

  localparam logic [30:0] TIME_STEP_RESET = 31'd655;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

  localparam int RECIP_QW = (2 * FRAC_BITS + 1 > 33) ? 2 * FRAC_BITS + 1 : 33;

  localparam int SUM_W  = 35;
  localparam int PROD_W = 66;
  localparam int M1_W   = PROD_W - FRAC_BITS;
  localparam int VP_W   = M1_W + 32;
  localparam int MAG_W  = 37;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 37'h10_0000_0000;

  localparam int          DIV3_HALF  = 18;
  localparam logic [16:0] DIV3_GROUP = 17'd87381;
  localparam logic [18:0] DIV3_RECIP = 19'd349526;
  localparam int          DIV3_SHIFT = 20;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][SUM_W-1:0] sum3_t;

  typedef struct packed {
    logic        is_load;
    logic [2:0]  stage;
    logic [PART_W-1:0] particle;
    vec3_t       pos;
    vec3_t       vel;
    vec3_t       frc;
    logic [30:0] mass;
  } item_t;

  typedef struct packed {
    sum3_t vs;
    sum3_t fs;
  } sums_t;

  typedef struct packed {
    vec3_t pos;
    vec3_t vel;
  } spv_t;

  typedef enum logic [1:0] {
    RC_IDLE,
    RC_RUN,
    RC_DONE
  } recip_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } recip_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } recip_sts_t;

endpackage
`default_nettype wire

FILE: src/rk4c_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rk4c_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [2:0]                cmd,
  input  wire logic [rk4c_pkg::PART_W-1:0] particle,
  input  wire rk4c_pkg::vec3_t           pos,
  input  wire rk4c_pkg::vec3_t           vel,
  input  wire rk4c_pkg::vec3_t           frc,
  input  wire logic [30:0]               mass,
  output logic                           head_valid,
  output rk4c_pkg::item_t                head,
  input  wire logic                      pop
);

  rk4c_pkg::item_t q_mem [rk4c_pkg::FIFO_DEPTH];
  logic [rk4c_pkg::FIFO_AW-1:0] wr_ptr;
  logic [rk4c_pkg::FIFO_AW-1:0] rd_ptr;
  logic [rk4c_pkg::FIFO_AW:0]   count;
  rk4c_pkg::item_t item;
  logic keep;
  logic push;
  logic do_pop;

  always_comb begin
    item.is_load  = (cmd == rk4c_pkg::CMD_LOAD);
    item.stage    = cmd;
    item.particle = particle;
    item.pos      = pos;
    item.vel      = vel;
    item.frc      = frc;
    item.mass     = mass;
  end

  // drop unused commands and out-of-range particles
  assign keep = (cmd <= rk4c_pkg::CMD_STAGE4) &&
                (32'(particle) < rk4c_pkg::PARTICLES);
  assign in_stall   = (count == rk4c_pkg::FIFO_FULL);
  assign push       = in_valid && !in_stall && keep;
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/rk4c_recip.sv
`timescale 1ns / 1ps
`default_nettype none
module rk4c_recip (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rk4c_pkg::recip_req_t req,
  input  wire logic [30:0]          mass,
  output rk4c_pkg::recip_sts_t      sts,
  output logic [31:0]               inv
);

  localparam int QW = rk4c_pkg::RECIP_QW;
  localparam int CW = $clog2(QW);

  rk4c_pkg::recip_state_t state;
  rk4c_pkg::recip_state_t state_next;
  logic [CW-1:0] cnt;
  logic [30:0]   dvs;
  logic [30:0]   rem;
  logic [30:0]   rem_next;
  logic [QW-1:0] quo;
  logic [31:0]   r_sh;
  logic          nbit;
  logic          qbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rk4c_pkg::RC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rk4c_pkg::RC_IDLE: begin
        if (req.start) begin
          state_next = rk4c_pkg::RC_RUN;
        end
      end
      rk4c_pkg::RC_RUN: begin
        if (cnt == '0) begin
          state_next = rk4c_pkg::RC_DONE;
        end
      end
      rk4c_pkg::RC_DONE: begin
        if (req.ack) begin
          state_next = rk4c_pkg::RC_IDLE;
        end
      end
      default: begin
        state_next = rk4c_pkg::RC_IDLE;
      end
    endcase
  end

  // numerator is a single one at bit 2*FRAC_BITS
  assign nbit     = (cnt == CW'(2 * rk4c_pkg::FRAC_BITS));
  assign r_sh     = {rem, nbit};
  assign qbit     = (r_sh >= {1'b0, dvs});
  assign rem_next = qbit ? 31'(r_sh - {1'b0, dvs}) : r_sh[30:0];

  always_ff @(posedge clk) begin
    if (state == rk4c_pkg::RC_IDLE && req.start) begin
      dvs <= mass;
      rem <= '0;
      quo <= '0;
      cnt <= CW'(QW - 1);
    end else if (state == rk4c_pkg::RC_RUN) begin
      rem <= rem_next;
      quo <= {quo[QW-2:0], qbit};
      cnt <= cnt - 1'b1;
    end
  end

  assign sts.idle = (state == rk4c_pkg::RC_IDLE);
  assign sts.done = (state == rk4c_pkg::RC_DONE);
  assign inv      = (|quo[QW-1:32]) ? 32'hFFFF_FFFF : quo[31:0];

endmodule
`default_nettype wire

FILE: src/rk4c_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rk4c_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [30:0]                 time_step,
  input  wire logic                        head_valid,
  input  wire rk4c_pkg::item_t             head,
  output logic                             pop,
  output rk4c_pkg::recip_req_t             rc_req,
  input  wire rk4c_pkg::recip_sts_t        rc_sts,
  input  wire logic [31:0]                 rc_inv,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rk4c_pkg::PART_W-1:0]      out_particle,
  output logic [2:0]                       out_stage,
  output rk4c_pkg::vec3_t                  new_pos,
  output rk4c_pkg::vec3_t                  new_vel
);

  localparam int PIPE_N = 9;
  localparam int IW     = rk4c_pkg::IDX_W;
  localparam int SW     = rk4c_pkg::SUM_W;
  localparam int M1W    = rk4c_pkg::M1_W;
  localparam int VPW    = rk4c_pkg::VP_W;
  localparam int MW     = rk4c_pkg::MAG_W;
  localparam int FB     = rk4c_pkg::FRAC_BITS;
  localparam int DH     = rk4c_pkg::DIV3_HALF;

  rk4c_pkg::spv_t  spv_mem   [rk4c_pkg::PARTICLES];
  logic [31:0]     inv_mem   [rk4c_pkg::PARTICLES];
  rk4c_pkg::vec3_t trial_mem [rk4c_pkg::PARTICLES];
  rk4c_pkg::sums_t sum_mem   [rk4c_pkg::PARTICLES];

  logic en;
  logic hazard;
  logic issue;
  logic load_go;
  logic [IW-1:0] head_idx;

  logic [PIPE_N-1:0]           vld;
  logic [rk4c_pkg::PART_W-1:0] part  [PIPE_N];
  logic [2:0]                  cmd_s [PIPE_N];
  logic [5:0]                  sgn   [2:PIPE_N-1];

  rk4c_pkg::vec3_t f1;
  rk4c_pkg::vec3_t tv1;
  rk4c_pkg::sums_t sums1;
  rk4c_pkg::sums_t sums_new;
  logic [SW-1:0]   op_next [6];
  logic [SW-1:0]   op2     [6];
  logic [SW-1:0]   mag3    [6];
  logic [62:0]     ppl4    [6];
  logic [33:0]     pph4    [6];
  logic [M1W-1:0]  m1_5    [6];
  logic [31:0]     inv5;
  logic [MW-1:0]   x6      [3];
  logic [63:0]     vl6     [3];
  logic [M1W-1:0]  vh6     [3];
  logic [MW-1:0]   x7      [6];
  logic [MW-1:0]   x8      [6];
  logic [34:0]     pa8     [6];
  logic [18:0]     s8      [6];
  logic [MW-1:0]   mag9    [6];
  rk4c_pkg::spv_t  spv9;
  rk4c_pkg::vec3_t res_pos;
  rk4c_pkg::vec3_t res_vel;

  function automatic logic [31:0] sat32(input logic [38:0] v);
    logic [31:0] r;
    if (v[38:31] == 8'h00 || v[38:31] == 8'hFF) begin
      r = v[31:0];
    end else if (v[38]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [MW-1:0] clamp_m1(input logic [M1W-1:0] v);
    return (v >= M1W'(rk4c_pkg::MAG_LIMIT)) ? rk4c_pkg::MAG_LIMIT : MW'(v);
  endfunction

  assign en       = !out_valid || !out_stall;
  assign head_idx = head.particle[IW-1:0];

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < PIPE_N; k++) begin
      if (vld[k] && part[k] == head.particle) begin
        hazard = 1'b1;
      end
    end
  end

  assign rc_req.start = head_valid && head.is_load && rc_sts.idle;
  assign load_go      = head_valid && head.is_load && rc_sts.done && !(|vld);
  assign rc_req.ack   = load_go;
  assign issue        = en && head_valid && !head.is_load && !hazard;
  assign pop          = issue || load_go;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_N-2:0], issue};
      out_valid <= vld[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part[0]  <= head.particle;
      cmd_s[0] <= head.stage;
      for (int k = 1; k < PIPE_N; k++) begin
        part[k]  <= part[k-1];
        cmd_s[k] <= cmd_s[k-1];
      end
    end
  end

  // issue: read trial state and sums
  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= head.frc;
      tv1   <= trial_mem[head_idx];
      sums1 <= sum_mem[head_idx];
    end
  end

  // stage 1: update weighted sums, choose operands
  always_comb begin
    logic [SW-1:0] tvx;
    logic [SW-1:0] fx;
    logic          first;
    logic          dbl;
    logic          fin;
    first = (cmd_s[0] == rk4c_pkg::CMD_STAGE1);
    dbl   = (cmd_s[0] == rk4c_pkg::CMD_STAGE2) || (cmd_s[0] == rk4c_pkg::CMD_STAGE3);
    fin   = (cmd_s[0] == rk4c_pkg::CMD_STAGE4);
    for (int c = 0; c < 3; c++) begin
      tvx = {{(SW - 32){tv1[c][31]}}, tv1[c]};
      fx  = {{(SW - 32){f1[c][31]}}, f1[c]};
      sums_new.vs[c] = first ? tvx : sums1.vs[c] + (dbl ? (tvx << 1) : tvx);
      sums_new.fs[c] = first ? fx  : sums1.fs[c] + (dbl ? (fx << 1) : fx);
      op_next[c]     = fin ? sums_new.vs[c] : tvx;
      op_next[3 + c] = fin ? sums_new.fs[c] : fx;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[0]) begin
      sum_mem[part[0][IW-1:0]] <= sums_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        op2[j] <= op_next[j];
      end
    end
  end

  // stage 2: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        mag3[j]   <= op2[j][SW-1] ? SW'(~op2[j]) + SW'(1) : op2[j];
        sgn[2][j] <= op2[j][SW-1];
      end
      for (int k = 3; k < PIPE_N; k++) begin
        sgn[k] <= sgn[k-1];
      end
    end
  end

  // stage 3: multiply by dt
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        ppl4[j] <= 63'(mag3[j][31:0]) * 63'(time_step);
        pph4[j] <= 34'(mag3[j][SW-1:32]) * 34'(time_step);
      end
    end
  end

  // stage 4: combine partial products, scale (half step on stages 1 and 2)
  always_ff @(posedge clk) begin
    logic [rk4c_pkg::PROD_W-1:0] prod;
    logic half;
    if (en) begin
      half = (cmd_s[3] < rk4c_pkg::CMD_STAGE3);
      for (int j = 0; j < 6; j++) begin
        prod    = rk4c_pkg::PROD_W'(ppl4[j]) + (rk4c_pkg::PROD_W'(pph4[j]) << 32);
        m1_5[j] <= half ? M1W'(prod >> (FB + 1)) : M1W'(prod >> FB);
      end
      inv5 <= inv_mem[part[3][IW-1:0]];
    end
  end

  // stage 5: clamp position, multiply velocity term by inverse mass
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        x6[c]  <= clamp_m1(m1_5[c]);
        vl6[c] <= 64'(m1_5[3 + c][31:0]) * 64'(inv5);
        vh6[c] <= M1W'(m1_5[3 + c][M1W-1:32]) * M1W'(inv5);
      end
    end
  end

  // stage 6: combine, scale and clamp velocity term
  always_ff @(posedge clk) begin
    logic [VPW-1:0] p;
    logic [VPW-1:0] v;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        p         = VPW'(vl6[c]) + (VPW'(vh6[c]) << 32);
        v         = p >> FB;
        x7[c]     <= x6[c];
        x7[3 + c] <= (v >= VPW'(rk4c_pkg::MAG_LIMIT)) ? rk4c_pkg::MAG_LIMIT : MW'(v);
      end
    end
  end

  // stage 7: divide by six, split into halves
  always_ff @(posedge clk) begin
    logic [MW-2:0] y;
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        y      = x7[j][MW-1:1];
        pa8[j] <= 35'(y[MW-2:DH]) * 35'(rk4c_pkg::DIV3_GROUP);
        s8[j]  <= 19'(y[MW-2:DH]) + 19'(y[DH-1:0]);
        x8[j]  <= x7[j];
      end
    end
  end

  // stage 8: finish divide, read start state
  always_ff @(posedge clk) begin
    logic [37:0] t;
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        t       = 38'(s8[j]) * 38'(rk4c_pkg::DIV3_RECIP);
        mag9[j] <= (cmd_s[7] == rk4c_pkg::CMD_STAGE4) ?
                   MW'(36'(pa8[j]) + 36'(t[37:rk4c_pkg::DIV3_SHIFT])) : x8[j];
      end
      spv9 <= spv_mem[part[7][IW-1:0]];
    end
  end

  // stage 9: add to start state and saturate
  always_comb begin
    logic [38:0] base;
    logic [38:0] m;
    for (int c = 0; c < 3; c++) begin
      base       = {{7{spv9.pos[c][31]}}, spv9.pos[c]};
      m          = {2'b00, mag9[c]};
      res_pos[c] = sat32(sgn[PIPE_N-1][c] ? base - m : base + m);
      base       = {{7{spv9.vel[c][31]}}, spv9.vel[c]};
      m          = {2'b00, mag9[3 + c]};
      res_vel[c] = sat32(sgn[PIPE_N-1][3 + c] ? base - m : base + m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_particle <= part[PIPE_N-1];
      out_stage    <= cmd_s[PIPE_N-1];
      new_pos      <= res_pos;
      new_vel      <= res_vel;
    end
  end

  // load writes start state; stages 1..3 write trial velocity back
  always_ff @(posedge clk) begin
    if (load_go) begin
      spv_mem[head_idx]   <= '{pos: head.pos, vel: head.vel};
      inv_mem[head_idx]   <= rc_inv;
      trial_mem[head_idx] <= head.vel;
    end else if (en && vld[PIPE_N-1] && cmd_s[PIPE_N-1] != rk4c_pkg::CMD_STAGE4) begin
      trial_mem[part[PIPE_N-1][IW-1:0]] <= res_vel;
    end
  end

endmodule
`default_nettype wire

FILE: src/rk4_particle_stage_combiner_core.sv
`timescale 1ns / 1ps
// RK4 stage engine for a store of 1024 particles, Q16.16 values.
// Input channel (in_valid / in_stall): cmd 0 loads a particle's start
// position, velocity and mass; cmd 1..4 carries the force of RK stage k.
// Output channel (out_valid / out_stall): one beat per stage item with the
// trial state (stages 1..3) or the final RK4 state (stage 4), saturated.
// cfg_write_en / cfg_write_data set the step dt; write only while idle.
// Stage items stream at one per cycle while no hazard, load or out_stall
// holds them. An item waits while an earlier item for the same particle
// is still in the 9-stage pipeline.
// A load runs the bit-serial reciprocal of the mass and waits for the
// pipeline to drain, so a load holds the back end until both are done;
// out_stall can keep the pipeline from draining and so prolong it.
// A 4-entry queue parts input from the pipeline; in_stall rises when full.
// out_stall with out_valid high freezes the pipeline and output register;
// input beats are still taken until the queue fills.
// Reset empties queue and pipeline and sets dt to 655; particle storage is
// not cleared, so a particle must be loaded before its stages are sent.
`default_nettype none
module rk4_particle_stage_combiner_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [30:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [9:0]  particle,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] vel_x,
  input  wire logic [31:0] vel_y,
  input  wire logic [31:0] vel_z,
  input  wire logic [31:0] force_x,
  input  wire logic [31:0] force_y,
  input  wire logic [31:0] force_z,
  input  wire logic [30:0] mass,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_particle,
  output logic [2:0]       stage,
  output logic [31:0]      new_pos_x,
  output logic [31:0]      new_pos_y,
  output logic [31:0]      new_pos_z,
  output logic [31:0]      new_vel_x,
  output logic [31:0]      new_vel_y,
  output logic [31:0]      new_vel_z
);

  logic [30:0]          time_step;
  logic                 head_valid;
  rk4c_pkg::item_t      head;
  logic                 pop;
  rk4c_pkg::recip_req_t rc_req;
  rk4c_pkg::recip_sts_t rc_sts;
  logic [31:0]          rc_inv;
  rk4c_pkg::vec3_t      new_pos;
  rk4c_pkg::vec3_t      new_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= rk4c_pkg::TIME_STEP_RESET;
    end else if (cfg_write_en) begin
      time_step <= cfg_write_data;
    end
  end

  rk4c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .particle   (particle),
    .pos        ({pos_z, pos_y, pos_x}),
    .vel        ({vel_z, vel_y, vel_x}),
    .frc        ({force_z, force_y, force_x}),
    .mass       (mass),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rk4c_recip u_recip (
    .clk  (clk),
    .rst  (rst),
    .req  (rc_req),
    .mass (head.mass),
    .sts  (rc_sts),
    .inv  (rc_inv)
  );

  rk4c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .time_step    (time_step),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .rc_req       (rc_req),
    .rc_sts       (rc_sts),
    .rc_inv       (rc_inv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_particle (out_particle),
    .out_stage    (stage),
    .new_pos      (new_pos),
    .new_vel      (new_vel)
  );

  assign new_pos_x = new_pos[0];
  assign new_pos_y = new_pos[1];
  assign new_pos_z = new_pos[2];
  assign new_vel_x = new_vel[0];
  assign new_vel_y = new_vel[1];
  assign new_vel_z = new_vel[2];

endmodule
`default_nettype wire

FILE: sim/rk4_step_checker.sv
`timescale 1ns / 1ps
module rk4_step_checker
  import rk4c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [30:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [9:0]  particle,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] force_x,
  input  logic [31:0] force_y,
  input  logic [31:0] force_z,
  input  logic [30:0] mass,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_particle,
  input  logic [2:0]  stage,
  input  logic [31:0] new_pos_x,
  input  logic [31:0] new_pos_y,
  input  logic [31:0] new_pos_z,
  input  logic [31:0] new_vel_x,
  input  logic [31:0] new_vel_y,
  input  logic [31:0] new_vel_z,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [9:0]  particle;
    logic [2:0]  stage;
    logic [31:0] pos [3];
    logic [31:0] vel [3];
  } state_beat_t;

  state_beat_t trial_q[$];

  logic [30:0]        dt;
  logic signed [31:0] start_pos [PARTICLES][3];
  logic signed [31:0] start_vel [PARTICLES][3];
  logic signed [31:0] trial_vel [PARTICLES][3];
  logic signed [34:0] vel_acc [PARTICLES][3];
  logic signed [34:0] force_acc [PARTICLES][3];
  logic [31:0]        recip_mass [PARTICLES];

  assign pending = trial_q.size();

  // a * b / 2^s toward zero, magnitude clamped to 2^62
  function automatic longint scale_q(longint a, logic [31:0] b, int s);
    logic [63:0]  m;
    logic [127:0] prod;
    logic         neg;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    prod = {64'b0, m} * {96'b0, b};
    prod = prod >> s;
    if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic predict_stage(logic [2:0] k, logic [9:0] p, logic [31:0] f [3]);
    state_beat_t r;
    longint      w, fv, tv, np, nv;
    int          h;
    w = (k == CMD_STAGE1 || k == CMD_STAGE4) ? 1 : 2;
    h = (k < CMD_STAGE3) ? FRAC_BITS + 1 : FRAC_BITS;
    r.particle = p;
    r.stage = k;
    for (int c = 0; c < 3; c++) begin
      fv = longint'(signed'(f[c]));
      tv = longint'(trial_vel[p][c]);
      if (k == CMD_STAGE1) begin
        vel_acc[p][c] = tv[34:0];
        force_acc[p][c] = fv[34:0];
      end else begin
        np = longint'(vel_acc[p][c]) + w * tv;
        vel_acc[p][c] = np[34:0];
        nv = longint'(force_acc[p][c]) + w * fv;
        force_acc[p][c] = nv[34:0];
      end
      if (k < CMD_STAGE4) begin
        np = longint'(start_pos[p][c]) + scale_q(tv, {1'b0, dt}, h);
        nv = longint'(start_vel[p][c]) +
             scale_q(scale_q(fv, {1'b0, dt}, h), recip_mass[p], FRAC_BITS);
      end else begin
        np = longint'(start_pos[p][c]) +
             scale_q(longint'(vel_acc[p][c]), {1'b0, dt}, FRAC_BITS) / 6;
        nv = longint'(start_vel[p][c]) +
             scale_q(scale_q(longint'(force_acc[p][c]), {1'b0, dt}, FRAC_BITS),
                     recip_mass[p], FRAC_BITS) / 6;
      end
      r.pos[c] = sat32(np);
      r.vel[c] = sat32(nv);
      if (k < CMD_STAGE4) trial_vel[p][c] = sat32(nv);
    end
    trial_q.push_back(r);
  endtask

  always @(posedge clk) begin
    logic [63:0]  inv;
    logic [31:0]  f [3];
    state_beat_t  e;
    logic [31:0]  gp [3];
    logic [31:0]  gv [3];
    if (rst) begin
      dt = TIME_STEP_RESET;
      fail_count = 0;
      trial_q.delete();
    end else begin
      if (cfg_write_en) dt = cfg_write_data;
      if (in_valid && !in_stall) begin
        if (cmd == CMD_LOAD) begin
          inv = 64'hffff_ffff;
          if (mass != 0) begin
            inv = (64'd1 << (2 * FRAC_BITS)) / mass;
            if (inv > 64'hffff_ffff) inv = 64'hffff_ffff;
          end
          recip_mass[particle] = inv[31:0];
          start_pos[particle] = '{pos_x, pos_y, pos_z};
          start_vel[particle] = '{vel_x, vel_y, vel_z};
          trial_vel[particle] = '{vel_x, vel_y, vel_z};
        end else if (cmd <= CMD_STAGE4) begin
          f = '{force_x, force_y, force_z};
          predict_stage(cmd, particle, f);
        end
      end
      if (out_valid && !out_stall) begin
        if (trial_q.size() == 0) begin
          $display("%0t: result beat for particle %0d with nothing pending",
                   $realtime, out_particle);
          fail_count++;
        end else begin
          e = trial_q.pop_front();
          gp = '{new_pos_x, new_pos_y, new_pos_z};
          gv = '{new_vel_x, new_vel_y, new_vel_z};
          if (out_particle !== e.particle)
            report("out_particle", 32'(out_particle), 32'(e.particle));
          if (stage !== e.stage) report("stage", 32'(stage), 32'(e.stage));
          for (int c = 0; c < 3; c++) begin
            if (gp[c] !== e.pos[c]) report($sformatf("new_pos[%0d]", c), gp[c], e.pos[c]);
            if (gv[c] !== e.vel[c]) report($sformatf("new_vel[%0d]", c), gv[c], e.vel[c]);
          end
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rk4c_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write_en = 0;
  logic [30:0] cfg_write_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [9:0]  particle = '0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [31:0] force_x = '0, force_y = '0, force_z = '0;
  logic [30:0] mass = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [9:0]  out_particle;
  logic [2:0]  stage;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z;
  logic [31:0] new_vel_x, new_vel_y, new_vel_z;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int load_count = 0;
  int stage_count = 0;
  int step_settings = 0;
  bit quiet = 0;
  bit loaded [PARTICLES];
  int stall_hold = 0;

  always #2 clk = ~clk;

  rk4_particle_stage_combiner_core DUT (.*);

  rk4_step_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall = ~out_stall & ($urandom_range(0, 2) == 0);
      stall_hold = out_stall ? gap_len() : $urandom_range(0, 6);
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
      3: return 32'($signed($urandom_range(0, 400_000)) - 200_000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_mass();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 31'd1;
      2: return 31'h7fff_ffff;
      3: return 31'd65536;
      4, 5, 6: return 31'($urandom_range(1, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic put_beat(logic [2:0] c, logic [9:0] p, logic [31:0] v [9], logic [30:0] m);
    int g;
    cmd = c;
    particle = p;
    {pos_x, pos_y, pos_z} = {v[0], v[1], v[2]};
    {vel_x, vel_y, vel_z} = {v[3], v[4], v[5]};
    {force_x, force_y, force_z} = {v[6], v[7], v[8]};
    mass = m;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (c == CMD_LOAD) begin
      load_count++;
      loaded[p] = 1;
    end else if (c <= CMD_STAGE4) begin
      stage_count++;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic load_random(logic [9:0] p);
    logic [31:0] v [9];
    foreach (v[i]) v[i] = pick32();
    put_beat(CMD_LOAD, p, v, pick_mass());
  endtask

  task automatic force_random(logic [2:0] k, logic [9:0] p);
    logic [31:0] v [9];
    foreach (v[i]) v[i] = pick32();
    put_beat(k, p, v, 31'($urandom));
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_step(logic [30:0] d);
    drain();
    cfg_write_data = d;
    cfg_write_en = 1;
    @(negedge clk);
    cfg_write_en = 0;
    step_settings++;
  endtask

  task automatic flat_beat(logic [2:0] c, logic [9:0] p, logic [31:0] x, logic [30:0] m);
    logic [31:0] v [9];
    foreach (v[i]) v[i] = x;
    put_beat(c, p, v, m);
  endtask

  initial begin
    logic [9:0] grp [$];
    logic [9:0] p;
    int         n;
    logic [30:0] steps [6];

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    flat_beat(CMD_LOAD, 0, 32'h7fff_ffff, 31'd1);
    flat_beat(CMD_LOAD, 1, 32'h8000_0000, 31'd0);
    flat_beat(CMD_LOAD, 2, 32'h0001_0000, 31'h7fff_ffff);
    flat_beat(CMD_LOAD, 1023, 32'h0000_0000, 31'd65536);
    for (int k = 1; k <= 4; k++) flat_beat(3'(k), 0, 32'h7fff_ffff, 0);
    for (int k = 1; k <= 4; k++) flat_beat(3'(k), 1, 32'h8000_0000, 0);
    flat_beat(CMD_STAGE1, 2, 32'h0003_0000, 0);
    flat_beat(CMD_STAGE4, 2, 32'hffff_0000, 0);
    flat_beat(CMD_STAGE2, 2, 32'h0002_0000, 0);
    flat_beat(CMD_STAGE1, 1023, 32'h7fff_ffff, 0);
    for (int i = 0; i < 6; i++) flat_beat(CMD_STAGE2, 1023, 32'h7fff_ffff, 0);
    flat_beat(CMD_STAGE4, 1023, 32'h7fff_ffff, 0);
    for (int c = 5; c <= 7; c++) flat_beat(3'(c), 0, 32'h1234_5678, 31'd5);

    steps = '{31'd1, 31'h7fff_ffff, 31'd65536, 31'($urandom_range(1, 1 << 18)),
              31'($urandom), TIME_STEP_RESET};
    foreach (steps[s]) begin
      set_step(steps[s]);
      quiet = (s == 2);
      n = 0;
      while (n < 185) begin
        if ($urandom_range(0, 9) == 0) begin
          grp.delete();
          for (int i = 0; i < 30; i++) if (loaded[$urandom_range(0, PARTICLES - 1)]) begin end
          p = 10'($urandom);
          if (!loaded[p]) p = 0;
          if ($urandom_range(0, 3) == 0) begin
            flat_beat(3'($urandom_range(5, 7)), 10'($urandom), pick32(), pick_mass());
          end else begin
            force_random(3'($urandom_range(1, 4)), p);
            n++;
          end
        end else begin
          grp.delete();
          repeat ($urandom_range(1, 6)) begin
            p = 10'($urandom);
            load_random(p);
            grp.push_back(p);
            n++;
          end
          for (int k = 1; k <= 4; k++) begin
            foreach (grp[i]) force_random(3'(k), grp[i]);
            n += grp.size();
          end
        end
        if (n > 90 && n < 100) begin
          in_valid = 0;
          while (pending != 0) @(negedge clk);
        end
      end
      quiet = 0;
    end

    drain();
    $display("Covered %0d loads and %0d stage beats over %0d step settings",
             load_count, stage_count, step_settings + 1);
    $display("including extreme values, zero mass, out-of-order stages and sum wrap");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: rk4_particle_stage_combiner_core.f
src/rk4c_pkg.sv
src/rk4c_front.sv
src/rk4c_recip.sv
src/rk4c_back.sv
src/rk4_particle_stage_combiner_core.sv
sim/rk4_step_checker.sv
sim/testbench.sv
